// ===== hdl/crcfp_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update of the frame parser.
package crcfp_pkg;

  // Payload store depth; frame lengths above it restart the hunt.
  localparam int unsigned MAX_PAYLOAD = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);

  // Depth of the queue between parser and output stage.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame bytes.
  localparam logic [7:0] SYNC_A        = 8'hC5;
  localparam logic [7:0] SYNC_B        = 8'h5C;
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam logic [7:0] CMD_SET_GAINS = 8'h01;
  localparam logic [7:0] CMD_STREAM    = 8'h02;
  localparam logic [7:0] LEN_SET_GAINS = 8'd13;
  localparam logic [7:0] LEN_STREAM    = 8'd1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] MAX_TARGET_RST = 8'd3;

  // Result kind codes.
  localparam logic KIND_STREAM = 1'b0;
  localparam logic KIND_GAINS  = 1'b1;

  typedef enum logic [2:0] {
    ST_SYNC_A,
    ST_SYNC_B,
    ST_VERSION,
    ST_COMMAND,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_CRC_LO,
    ST_CRC_HI
  } parse_state_e;

  // One decoded frame.
  typedef struct packed {
    logic        kind;
    logic        enabled;
    logic [7:0]  target;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
  } frame_t;

  // Parser to queue.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_push_t;

  // Queue head toward the output stage.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_head_t;

  // Reflected CRC-16 update with one byte, bit by bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crcfp_if.sv =====
// Channel interfaces: received bytes, configuration writes and decoded results.
interface crcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_target;

  modport source (output valid, output max_target, input ready);
  modport sink (input valid, input max_target, output ready);
endinterface

interface crcfp_res_if;
  logic        valid;
  logic        ready;
  logic        command_kind;
  logic        stream_enabled;
  logic [7:0]  gain_target;
  logic [31:0] kp_bits;
  logic [31:0] ki_bits;
  logic [31:0] kd_bits;

  modport source (output valid, output command_kind, output stream_enabled,
                  output gain_target, output kp_bits, output ki_bits, output kd_bits,
                  input ready);
  modport sink (input valid, input command_kind, input stream_enabled,
                input gain_target, input kp_bits, input ki_bits, input kd_bits,
                output ready);
endinterface

// ===== hdl/crcfp_front.sv =====
// Frame hunter: sync search, CRC tracking, payload capture and command classification.
module crcfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  crcfp_byte_if.sink        rx_i,
  input  logic              room_i,
  output crcfp_pkg::q_push_t push_o
);
  import crcfp_pkg::*;

  parse_state_e     state_q, state_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       cmd_q, len_q, crc_lo_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       store_q [MAX_PAYLOAD];

  logic        fire;
  logic [7:0]  b;
  logic [CNT_W-1:0] cnt_inc;
  logic        crc_good;
  logic        is_stream;
  logic        is_gains;

  assign rx_i.ready = room_i;
  assign fire       = rx_i.valid && room_i;
  assign b          = rx_i.rx_byte;
  assign cnt_inc    = cnt_q + CNT_W'(1);

  // Next state of the hunt.
  always_comb begin
    state_d = state_q;
    if (fire) begin
      unique case (state_q)
        ST_SYNC_A: begin
          if (b == SYNC_A) state_d = ST_SYNC_B;
        end
        ST_SYNC_B: begin
          if (b == SYNC_B) begin
            state_d = ST_VERSION;
          end else if (b != SYNC_A) begin
            state_d = ST_SYNC_A;
          end
        end
        ST_VERSION: begin
          state_d = (b == FRAME_VERSION) ? ST_COMMAND : ST_SYNC_A;
        end
        ST_COMMAND: begin
          state_d = ST_LENGTH;
        end
        ST_LENGTH: begin
          if (b > 8'(MAX_PAYLOAD)) begin
            state_d = ST_SYNC_A;
          end else if (b == 8'd0) begin
            state_d = ST_CRC_LO;
          end else begin
            state_d = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (8'(cnt_inc) >= len_q) state_d = ST_CRC_LO;
        end
        ST_CRC_LO: begin
          state_d = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          state_d = ST_SYNC_A;
        end
      endcase
    end
  end

  // Running CRC and payload count.
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (fire) begin
      unique case (state_q)
        ST_VERSION: crc_d = crc_feed(CRC_INIT, b);
        ST_COMMAND: crc_d = crc_feed(crc_q, b);
        ST_LENGTH: begin
          crc_d = crc_feed(crc_q, b);
          cnt_d = '0;
        end
        ST_PAYLOAD: begin
          crc_d = crc_feed(crc_q, b);
          cnt_d = cnt_inc;
        end
        ST_SYNC_A, ST_SYNC_B, ST_CRC_LO, ST_CRC_HI: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  // Classify the frame on its last byte.
  assign crc_good  = ({b, crc_lo_q} == crc_q);
  assign is_stream = (cmd_q == CMD_STREAM) && (len_q == LEN_STREAM);
  assign is_gains  = (cmd_q == CMD_SET_GAINS) && (len_q == LEN_SET_GAINS);

  always_comb begin
    push_o.valid         = fire && (state_q == ST_CRC_HI) && crc_good &&
                           (is_stream || is_gains);
    push_o.frame.kind    = is_gains ? KIND_GAINS : KIND_STREAM;
    push_o.frame.enabled = is_stream && (store_q[0] != 8'd0);
    push_o.frame.target  = is_gains ? store_q[0] : 8'd0;
    push_o.frame.kp      = is_gains ? {store_q[4], store_q[3], store_q[2], store_q[1]} : '0;
    push_o.frame.ki      = is_gains ? {store_q[8], store_q[7], store_q[6], store_q[5]} : '0;
    push_o.frame.kd      = is_gains ? {store_q[12], store_q[11], store_q[10], store_q[9]} : '0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC_A;
      crc_q   <= CRC_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
    end
  end

  // Capture header, CRC low byte and payload bytes.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (state_q == ST_COMMAND) cmd_q <= b;
      if (state_q == ST_LENGTH) len_q <= b;
      if (state_q == ST_CRC_LO) crc_lo_q <= b;
      if (state_q == ST_PAYLOAD) store_q[cnt_q[IDX_W-1:0]] <= b;
    end
  end

`ifndef SYNTHESIS
  a_payload_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAYLOAD) |-> (len_q != 8'd0 && len_q <= 8'(MAX_PAYLOAD) && 8'(cnt_q) < len_q))
    else $error("payload count out of frame bounds");
`endif

endmodule

// ===== hdl/crcfp_fifo.sv =====
// Short queue of decoded frames between the parser and the output stage.
module crcfp_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crcfp_pkg::q_push_t push_i,
  input  logic               pop_i,
  output crcfp_pkg::q_head_t head_o,
  output logic               room_o
);
  import crcfp_pkg::*;

  frame_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign room_o       = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push_i.valid && room_o;
  assign do_pop       = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.frame = mem_q[rd_q];

  // Advance pointers and fill count.
  always_comb begin
    wr_d  = do_push ? ptr_next(wr_q) : wr_q;
    rd_d  = do_pop ? ptr_next(rd_q) : rd_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed frame.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.frame;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> room_o)
    else $error("frame pushed into a full queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");
`endif

endmodule

// ===== hdl/crcfp_back.sv =====
// Output stage: target limit check, config register and the result register.
module crcfp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  crcfp_cfg_if.sink          cfg_i,
  input  crcfp_pkg::q_head_t head_i,
  output logic               pop_o,
  crcfp_res_if.source        res_o
);
  import crcfp_pkg::*;

  logic [7:0] max_target_q;
  logic       out_valid_q, out_valid_d;
  frame_t     out_q;
  logic       slot_free;
  logic       keep;

  assign cfg_i.ready = 1'b1;

  // Drop set-gains frames whose target is above the limit.
  assign slot_free   = !out_valid_q || res_o.ready;
  assign pop_o       = head_i.valid && slot_free;
  assign keep        = (head_i.frame.kind == KIND_STREAM) ||
                       (head_i.frame.target <= max_target_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (slot_free) out_valid_d = pop_o && keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_target_q <= MAX_TARGET_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) max_target_q <= cfg_i.max_target;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result beat.
  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= head_i.frame;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.command_kind   = out_q.kind;
  assign res_o.stream_enabled = out_q.enabled;
  assign res_o.gain_target    = out_q.target;
  assign res_o.kp_bits        = out_q.kp;
  assign res_o.ki_bits        = out_q.ki;
  assign res_o.kd_bits        = out_q.kd;

`ifndef SYNTHESIS
  a_target_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.command_kind == KIND_GAINS) |-> (res_o.gain_target <= max_target_q))
    else $error("set-gains result above target limit");
`endif

endmodule

// ===== hdl/crc_framed_command_parser.sv =====
// Top level of the CRC-framed serial command parser.
//
//   channel  dir  payload                                       beat taken when
//   rx_i     in   rx_byte[7:0]                                  valid && ready
//   cfg_i    in   max_target[7:0]                               valid && ready
//   res_o    out  command_kind, stream_enabled, gain_target,    valid && ready
//                 kp_bits, ki_bits, kd_bits
//
// One received byte per cycle while the queue has room; byte-wise CRC update and parser
// step happen in the same cycle. Results pass the queue, then the result register.
// rx_i.ready drops only while the two-entry frame queue is full.
// cfg_i is always ready. Reset returns the parser to the sync hunt, limit to 3.
module crc_framed_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  crcfp_byte_if.sink  rx_i,
  crcfp_cfg_if.sink   cfg_i,
  crcfp_res_if.source res_o
);
  import crcfp_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    room;
  logic    pop;

  crcfp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .room_i (room),
    .push_o (push)
  );

  crcfp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .room_o (room)
  );

  crcfp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

// ===== tb/sv/tb_crc_framed_command_parser.sv =====
// Self-checking testbench for the CRC-framed serial command parser.
module tb_crc_framed_command_parser;
  import crcfp_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  crcfp_byte_if rx_if ();
  crcfp_cfg_if  cfg_if ();
  crcfp_res_if  res_if ();

  crc_framed_command_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and scoreboard storage
  logic [7:0]  rx_bytes_pending[$];
  logic [7:0]  frame_body[$];
  frame_t      frames_due[$];
  int unsigned bytes_queued = 0;
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          pacing_on    = 1'b1;
  int unsigned hold_asked   = 0;

  // Predictor state
  parse_state_e hunt_state;
  logic [7:0]   cmd_seen;
  logic [7:0]   len_seen;
  int unsigned  body_count;
  logic [7:0]   crc_lo_seen;
  logic [15:0]  frame_crc;
  logic [7:0]   body_seen[MAX_PAYLOAD];
  logic [7:0]   gain_limit;

  // Advance a reflected CRC-16 over one byte, LSB first
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ d[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    return pacing_on ? $urandom_range(0, 6) : 0;
  endfunction

  function automatic void clear_hunt();
    hunt_state  = ST_SYNC_A;
    cmd_seen    = '0;
    len_seen    = '0;
    body_count  = 0;
    crc_lo_seen = '0;
    frame_crc   = CRC_INIT;
    for (int k = 0; k < MAX_PAYLOAD; k++) begin
      body_seen[k] = '0;
    end
  endfunction

  // Step the frame hunt by one byte; queue a decoded command when a frame closes
  task automatic parse_byte(input logic [7:0] b);
    frame_t f;
    case (hunt_state)
      ST_SYNC_A: begin
        if (b == SYNC_A) hunt_state = ST_SYNC_B;
      end
      ST_SYNC_B: begin
        if (b == SYNC_B) begin
          hunt_state = ST_VERSION;
        end else if (b != SYNC_A) begin
          clear_hunt();
        end
      end
      ST_VERSION: begin
        if (b == FRAME_VERSION) begin
          frame_crc  = modbus_crc_byte(CRC_INIT, b);
          hunt_state = ST_COMMAND;
        end else begin
          clear_hunt();
        end
      end
      ST_COMMAND: begin
        cmd_seen   = b;
        frame_crc  = modbus_crc_byte(frame_crc, b);
        hunt_state = ST_LENGTH;
      end
      ST_LENGTH: begin
        if (b > MAX_PAYLOAD) begin
          clear_hunt();
        end else begin
          len_seen   = b;
          body_count = 0;
          frame_crc  = modbus_crc_byte(frame_crc, b);
          hunt_state = (b == 8'd0) ? ST_CRC_LO : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        body_seen[body_count] = b;
        frame_crc = modbus_crc_byte(frame_crc, b);
        body_count++;
        if (body_count >= len_seen) hunt_state = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        crc_lo_seen = b;
        hunt_state  = ST_CRC_HI;
      end
      default: begin
        f = '0;
        if ({b, crc_lo_seen} == frame_crc) begin
          if (cmd_seen == CMD_STREAM && len_seen == LEN_STREAM) begin
            f.kind    = KIND_STREAM;
            f.enabled = (body_seen[0] != 8'h00);
            frames_due.push_back(f);
          end else if (cmd_seen == CMD_SET_GAINS && len_seen == LEN_SET_GAINS &&
                       body_seen[0] <= gain_limit) begin
            f.kind   = KIND_GAINS;
            f.target = body_seen[0];
            f.kp     = {body_seen[4], body_seen[3], body_seen[2], body_seen[1]};
            f.ki     = {body_seen[8], body_seen[7], body_seen[6], body_seen[5]};
            f.kd     = {body_seen[12], body_seen[11], body_seen[10], body_seen[9]};
            frames_due.push_back(f);
          end
        end
        clear_hunt();
      end
    endcase
  endtask

  // Frame building
  task automatic put_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic fill_body(input int unsigned n);
    for (int k = 0; k < n; k++) begin
      frame_body.push_back(8'($urandom));
    end
  endtask

  // Emit sync, header, the staged body and the CRC; optionally flip one CRC bit
  task automatic push_frame(input logic [7:0] ver, input logic [7:0] cmd,
                            input logic [7:0] len, input bit bad_crc);
    logic [15:0] crc;
    crc = modbus_crc_byte(CRC_INIT, ver);
    crc = modbus_crc_byte(crc, cmd);
    crc = modbus_crc_byte(crc, len);
    foreach (frame_body[k]) crc = modbus_crc_byte(crc, frame_body[k]);
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    put_byte(SYNC_A);
    put_byte(SYNC_B);
    put_byte(ver);
    put_byte(cmd);
    put_byte(len);
    foreach (frame_body[k]) put_byte(frame_body[k]);
    put_byte(crc[7:0]);
    put_byte(crc[15:8]);
    frame_body.delete();
  endtask

  task automatic push_stream(input logic [7:0] flag, input bit bad_crc);
    frame_body.push_back(flag);
    push_frame(FRAME_VERSION, CMD_STREAM, LEN_STREAM, bad_crc);
  endtask

  task automatic push_gains(input logic [7:0] tgt, input logic [31:0] kp,
                            input logic [31:0] ki, input logic [31:0] kd, input bit bad_crc);
    frame_body.push_back(tgt);
    for (int k = 0; k < 4; k++) frame_body.push_back(kp[8*k +: 8]);
    for (int k = 0; k < 4; k++) frame_body.push_back(ki[8*k +: 8]);
    for (int k = 0; k < 4; k++) frame_body.push_back(kd[8*k +: 8]);
    push_frame(FRAME_VERSION, CMD_SET_GAINS, LEN_SET_GAINS, bad_crc);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise
  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned start_total;
    int unsigned pick;
    logic [7:0]  tgt;
    logic [7:0]  cmd;
    logic [7:0]  ver;
    start_total = bytes_queued;
    while (bytes_queued - start_total < n_bytes) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) put_byte(SYNC_A);
      case ($urandom_range(0, 4))
        0: tgt = gain_limit;
        1: tgt = gain_limit + 8'd1;
        2: tgt = 8'h00;
        3: tgt = 8'hFF;
        default: tgt = 8'($urandom);
      endcase
      if (pick < 35) begin
        push_stream(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'b0);
      end else if (pick < 70) begin
        push_gains(tgt, $urandom, $urandom, $urandom, 1'b0);
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_SET_GAINS;
          1: cmd = CMD_STREAM;
          default: cmd = 8'($urandom);
        endcase
        fill_body($urandom_range(0, MAX_PAYLOAD));
        push_frame(FRAME_VERSION, cmd, 8'(frame_body.size()), 1'b0);
      end else if (pick < 88) begin
        if (pick[0]) begin
          push_stream(8'($urandom), 1'b1);
        end else begin
          push_gains(tgt, $urandom, $urandom, $urandom, 1'b1);
        end
      end else if (pick < 91) begin
        put_byte(SYNC_A);
        put_byte(8'($urandom));
      end else if (pick < 94) begin
        ver = 8'($urandom);
        if (ver == FRAME_VERSION) ver = ~ver;
        fill_body(2);
        push_frame(ver, CMD_STREAM, LEN_STREAM, 1'b0);
      end else if (pick < 97) begin
        fill_body(3);
        push_frame(FRAME_VERSION, CMD_STREAM, 8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
      end
    end
  endtask

  // Wait until every byte is taken and every expected command has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_bytes_pending.size() != 0 || rx_if.valid || frames_due.size() != 0);
  endtask

  // Write the target limit while the parser is idle
  task automatic write_limit(input logic [7:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_if.max_target <= value;
    cfg_if.valid      <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Byte driver: draw a gap after each beat, hold the byte while stalled
  int unsigned byte_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      byte_gap      <= 0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (byte_gap != 0) begin
        rx_if.valid <= 1'b0;
        byte_gap    <= byte_gap - 1;
      end else if (rx_bytes_pending.size() != 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_bytes_pending.pop_front();
        byte_gap      <= pick_gap();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: draw a stall after each beat, and hold off for a long stretch on request
  int unsigned result_stall;
  int unsigned hold_left;
  int unsigned hold_taken;
  always @(posedge clk_i or negedge rst_ni) begin : take_results
    int unsigned stall_draw;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      result_stall <= 0;
      hold_left    <= 0;
      hold_taken   <= 0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      res_if.ready <= 1'b0;
      hold_taken   <= hold_asked;
      hold_left    <= HOLD_CYCLES;
    end else if (result_stall != 0) begin
      res_if.ready <= 1'b0;
      result_stall <= result_stall - 1;
    end else if (res_if.valid && res_if.ready) begin
      stall_draw   = pick_gap();
      res_if.ready <= (stall_draw == 0);
      result_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Monitor: track config writes, predict on byte beats, check result beats
  always @(posedge clk_i) begin : observe
    frame_t got;
    frame_t want;
    string  diff;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) gain_limit = cfg_if.max_target;
      if (rx_if.valid && rx_if.ready) parse_byte(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) begin
        got.kind    = res_if.command_kind;
        got.enabled = res_if.stream_enabled;
        got.target  = res_if.gain_target;
        got.kp      = res_if.kp_bits;
        got.ki      = res_if.ki_bits;
        got.kd      = res_if.kd_bits;
        if (frames_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result: kind %0d en %0d target %0d kp %h ki %h kd %h",
                     got.kind, got.enabled, got.target, got.kp, got.ki, got.kd);
          end
        end else begin
          want = frames_due.pop_front();
          diff = "";
          if (got.kind !== want.kind) diff = {diff, " command_kind"};
          if (got.enabled !== want.enabled) diff = {diff, " stream_enabled"};
          if (got.target !== want.target) diff = {diff, " gain_target"};
          if (got.kp !== want.kp) diff = {diff, " kp_bits"};
          if (got.ki !== want.ki) diff = {diff, " ki_bits"};
          if (got.kd !== want.kd) diff = {diff, " kd_bits"};
          if (diff != "") begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch in%s: expected kind %0d en %0d target %0d kp %h ki %h kd %h",
                       diff, want.kind, want.enabled, want.target, want.kp, want.ki, want.kd);
              $display("  got kind %0d en %0d target %0d kp %h ki %h kd %h",
                       got.kind, got.enabled, got.target, got.kp, got.ki, got.kd);
            end
          end
        end
      end
    end else begin
      // Hold the predictor at its reset state
      gain_limit = MAX_TARGET_RST;
      clear_hunt();
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.max_target = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset limit
    push_stream(8'h01, 1'b0);
    push_stream(8'h00, 1'b0);
    push_gains(MAX_TARGET_RST, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 1'b0);
    push_gains(MAX_TARGET_RST + 8'd1, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 1'b0);
    push_gains(8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b0);
    // repeated sync byte before the second sync byte
    put_byte(SYNC_A);
    put_byte(SYNC_A);
    push_stream(8'hFF, 1'b0);
    // first sync byte followed by junk
    put_byte(SYNC_A);
    put_byte(8'h00);
    // bad version that looks like a sync byte, then a good frame
    put_byte(SYNC_A);
    put_byte(SYNC_B);
    put_byte(SYNC_A);
    put_byte(SYNC_B);
    push_stream(8'h80, 1'b0);
    // oversized length
    fill_body(MAX_PAYLOAD + 1);
    push_frame(FRAME_VERSION, CMD_STREAM, 8'(MAX_PAYLOAD + 1), 1'b0);
    // full-size payload with an unknown command
    fill_body(MAX_PAYLOAD);
    push_frame(FRAME_VERSION, 8'h03, 8'(MAX_PAYLOAD), 1'b0);
    // zero length, both commands
    push_frame(FRAME_VERSION, CMD_STREAM, 8'd0, 1'b0);
    push_frame(FRAME_VERSION, CMD_SET_GAINS, 8'd0, 1'b0);
    // bad CRC
    push_stream(8'h01, 1'b1);
    push_gains(8'h01, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_F0F0, 1'b1);
    // wrong lengths
    fill_body(2);
    push_frame(FRAME_VERSION, CMD_STREAM, 8'd2, 1'b0);
    fill_body(12);
    push_frame(FRAME_VERSION, CMD_SET_GAINS, 8'd12, 1'b0);
    push_frame(FRAME_VERSION, CMD_SET_GAINS, 8'd0, 1'b0);
    fill_body(1);
    push_frame(FRAME_VERSION, CMD_SET_GAINS, LEN_STREAM, 1'b0);
    fill_body(13);
    push_frame(FRAME_VERSION, CMD_STREAM, LEN_SET_GAINS, 1'b0);
    // unknown command codes at the extremes
    push_frame(FRAME_VERSION, 8'h00, 8'd0, 1'b0);
    fill_body(1);
    push_frame(FRAME_VERSION, 8'hFF, LEN_STREAM, 1'b0);

    // Lowest limit
    write_limit(8'h00);
    push_gains(8'h00, $urandom, $urandom, $urandom, 1'b0);
    push_gains(8'h01, $urandom, $urandom, $urandom, 1'b0);
    queue_random_traffic(50);

    // Highest limit, back-to-back bytes with no idling
    write_limit(8'hFF);
    pacing_on = 1'b0;
    push_gains(8'hFF, $urandom, $urandom, $urandom, 1'b0);
    queue_random_traffic(40);

    // Pause until all results are out, then fill the parser behind a stalled receiver
    wait_drained();
    hold_asked++;
    repeat (8) push_stream(8'($urandom), 1'b0);
    push_gains(gain_limit, $urandom, $urandom, $urandom, 1'b0);
    push_gains(8'h00, $urandom, $urandom, $urandom, 1'b0);

    // Mid-range limit with random pacing
    write_limit(8'($urandom_range(1, 254)));
    pacing_on = 1'b1;
    queue_random_traffic(60);

    write_limit(MAX_TARGET_RST);
    queue_random_traffic(30);

    // Drain and let the output stage settle
    wait_drained();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (error_count == 0 && frames_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
